FILE: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

FILE: hw/rtl/gbfp_pkg.sv
`default_nettype none

package gbfp_pkg;

	// register reset values
	localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND_RST = 8'h44;
	localparam logic [7:0]  SYNC_THIRD_RST  = 8'h12;
	localparam logic [31:0] CRC_POLY_RST    = 32'hEDB88320;

	// framing constants
	localparam int MAX_FRAME_BYTES = 4096;
	localparam int SHADOW_DEPTH    = 20;
	localparam int CRC_BYTES       = 4;
	localparam int BODY_LEN_LO_AT  = 8;
	localparam int BODY_LEN_HI_AT  = 9;
	localparam int QUEUE_DEPTH     = 4;
	localparam int CFG_DATA_W      = 32;
	localparam int CFG_INDEX_W     = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SYNC_FIRST  = 2'd0,
		CFG_SYNC_SECOND = 2'd1,
		CFG_SYNC_THIRD  = 2'd2,
		CFG_CRC_POLY    = 2'd3
	} cfg_reg_e;

	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [7:0]  sync_third;
		logic [31:0] crc_poly;
	} cfg_t;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_SYNC1  = 3'd1,
		PH_SYNC2  = 3'd2,
		PH_LEN    = 3'd3,
		PH_HEADER = 3'd4,
		PH_BODY   = 3'd5,
		PH_CRC    = 3'd6
	} phase_e;

	// work handed from the framing front to the crc and event back
	typedef enum logic [2:0] {
		OP_START    = 3'd0,
		OP_HDR      = 3'd1,
		OP_HDR_LONG = 3'd2,
		OP_SHORT    = 3'd3,
		OP_BODY     = 3'd4,
		OP_CRC      = 3'd5,
		OP_CRC_LAST = 3'd6
	} op_e;

	typedef struct packed {
		op_e         op;
		logic [7:0]  data;
		logic [11:0] idx;
	} op_t;

	typedef enum logic [1:0] {
		EV_BODY    = 2'd0,
		EV_GOOD    = 2'd1,
		EV_BAD     = 2'd2,
		EV_LEN_ERR = 2'd3
	} ev_kind_e;

	typedef struct packed {
		ev_kind_e    event_kind;
		logic [7:0]  data_byte;
		logic [11:0] body_index;
		logic [15:0] message_id;
		logic [15:0] body_length;
		logic [7:0]  time_status;
		logic [15:0] gps_week;
		logic [31:0] week_milliseconds;
		logic [31:0] received_crc;
		logic [31:0] computed_crc;
	} ev_t;

	// reflected crc-32 update by one byte, shift-right form
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b,
		input logic [31:0] poly);
		logic [31:0] t;
		t = {24'd0, crc[7:0] ^ b};
		for (int k = 0; k < 8; k++) begin
			if (t[0]) begin
				t = (t >> 1) ^ poly;
			end else begin
				t = t >> 1;
			end
		end
		return {8'd0, crc[31:8]} ^ t;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gbfp_in_if.sv
`default_nettype none

interface gbfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gbfp_out_if.sv
`default_nettype none

interface gbfp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [7:0]  data_byte;
	logic [11:0] body_index;
	logic [15:0] message_id;
	logic [15:0] body_length;
	logic [7:0]  time_status;
	logic [15:0] gps_week;
	logic [31:0] week_milliseconds;
	logic [31:0] received_crc;
	logic [31:0] computed_crc;

	modport source (output valid, output event_kind, output data_byte, output body_index,
		output message_id, output body_length, output time_status, output gps_week,
		output week_milliseconds, output received_crc, output computed_crc, input ready);
	modport sink (input valid, input event_kind, input data_byte, input body_index,
		input message_id, input body_length, input time_status, input gps_week,
		input week_milliseconds, input received_crc, input computed_crc, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gbfp_front.sv
`default_nettype none

module gbfp_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire gbfp_pkg::cfg_t  cfg,
	input  wire logic            in_valid,
	input  wire logic [7:0]      in_byte,
	input  wire logic            push_ready,
	output logic                 push_valid,
	output gbfp_pkg::op_t        push_item
);

	localparam int FRAME_W = 18;

	gbfp_pkg::phase_e phase_q, phase_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  hdr_len_q, hdr_len_d;
	logic [15:0] bl_q, bl_d;
	logic [15:0] body_len_q, body_len_d;

	logic acc;
	logic hdr_short;
	logic hdr_last;
	logic too_long;
	logic body_last;
	logic crc_last;
	logic [FRAME_W-1:0] frame_len;

	// frame position decode
	assign acc       = in_valid && push_ready;
	assign hdr_short = in_byte < 8'(gbfp_pkg::SHADOW_DEPTH);
	assign hdr_last  = ({1'b0, count_q} + 17'd1) >= {9'd0, hdr_len_q};
	assign frame_len = {10'd0, hdr_len_q} + {2'd0, bl_q};
	assign too_long  = frame_len > FRAME_W'(gbfp_pkg::MAX_FRAME_BYTES);
	assign body_last = ({1'b0, count_q} + 17'd1) >= {1'b0, body_len_q};
	assign crc_last  = count_q[1:0] == 2'(gbfp_pkg::CRC_BYTES - 1);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (acc) begin
			case (phase_q)
				gbfp_pkg::PH_HUNT: begin
					if (in_byte == cfg.sync_first) phase_d = gbfp_pkg::PH_SYNC1;
				end
				gbfp_pkg::PH_SYNC1: begin
					phase_d = (in_byte == cfg.sync_second) ? gbfp_pkg::PH_SYNC2
						: gbfp_pkg::PH_HUNT;
				end
				gbfp_pkg::PH_SYNC2: begin
					phase_d = (in_byte == cfg.sync_third) ? gbfp_pkg::PH_LEN
						: gbfp_pkg::PH_HUNT;
				end
				gbfp_pkg::PH_LEN: begin
					phase_d = hdr_short ? gbfp_pkg::PH_HUNT : gbfp_pkg::PH_HEADER;
				end
				gbfp_pkg::PH_HEADER: begin
					if (hdr_last) begin
						if (too_long) begin
							phase_d = gbfp_pkg::PH_HUNT;
						end else if (bl_q == 16'd0) begin
							phase_d = gbfp_pkg::PH_CRC;
						end else begin
							phase_d = gbfp_pkg::PH_BODY;
						end
					end
				end
				gbfp_pkg::PH_BODY: begin
					if (body_last) phase_d = gbfp_pkg::PH_CRC;
				end
				gbfp_pkg::PH_CRC: begin
					if (crc_last) phase_d = gbfp_pkg::PH_HUNT;
				end
				default: phase_d = gbfp_pkg::PH_HUNT;
			endcase
		end
	end

	// counters and the item pushed to the back part
	always_comb begin
		count_d        = count_q;
		hdr_len_d      = hdr_len_q;
		bl_d           = bl_q;
		body_len_d     = body_len_q;
		push_valid     = 1'b0;
		push_item.op   = gbfp_pkg::OP_HDR;
		push_item.data = in_byte;
		push_item.idx  = count_q[11:0];
		if (acc) begin
			case (phase_q)
				gbfp_pkg::PH_HUNT: begin
					if (in_byte == cfg.sync_first) begin
						push_valid    = 1'b1;
						push_item.op  = gbfp_pkg::OP_START;
						push_item.idx = 12'd0;
						count_d       = 16'd1;
					end
				end
				gbfp_pkg::PH_SYNC1: begin
					if (in_byte == cfg.sync_second) begin
						push_valid = 1'b1;
						count_d    = count_q + 16'd1;
					end
				end
				gbfp_pkg::PH_SYNC2: begin
					if (in_byte == cfg.sync_third) begin
						push_valid = 1'b1;
						count_d    = count_q + 16'd1;
					end
				end
				gbfp_pkg::PH_LEN: begin
					push_valid = 1'b1;
					if (hdr_short) begin
						push_item.op = gbfp_pkg::OP_SHORT;
					end else begin
						hdr_len_d = in_byte;
						count_d   = count_q + 16'd1;
					end
				end
				gbfp_pkg::PH_HEADER: begin
					push_valid = 1'b1;
					count_d    = count_q + 16'd1;
					if (count_q == 16'(gbfp_pkg::BODY_LEN_LO_AT)) bl_d[7:0] = in_byte;
					if (count_q == 16'(gbfp_pkg::BODY_LEN_HI_AT)) bl_d[15:8] = in_byte;
					if (hdr_last) begin
						if (too_long) begin
							push_item.op = gbfp_pkg::OP_HDR_LONG;
						end else begin
							count_d    = 16'd0;
							body_len_d = bl_q;
						end
					end
				end
				gbfp_pkg::PH_BODY: begin
					push_valid   = 1'b1;
					push_item.op = gbfp_pkg::OP_BODY;
					count_d      = body_last ? 16'd0 : count_q + 16'd1;
				end
				gbfp_pkg::PH_CRC: begin
					push_valid   = 1'b1;
					push_item.op = crc_last ? gbfp_pkg::OP_CRC_LAST : gbfp_pkg::OP_CRC;
					count_d      = count_q + 16'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= gbfp_pkg::PH_HUNT;
			count_q    <= '0;
			hdr_len_q  <= '0;
			bl_q       <= '0;
			body_len_q <= '0;
		end else begin
			phase_q    <= phase_d;
			count_q    <= count_d;
			hdr_len_q  <= hdr_len_d;
			bl_q       <= bl_d;
			body_len_q <= body_len_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/gbfp_queue.sv
`default_nettype none

module gbfp_queue #(
	parameter int DEPTH = gbfp_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	input  wire gbfp_pkg::op_t  push_item,
	output logic                push_ready,
	output logic                pop_valid,
	output gbfp_pkg::op_t       pop_item,
	input  wire logic           pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gbfp_pkg::op_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] level_q;
	logic do_push;
	logic do_pop;

	assign push_ready = level_q != CNT_W'(DEPTH);
	assign pop_valid  = level_q != '0;
	assign pop_item   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) entries_q[wr_ptr_q] <= push_item;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   level_q <= level_q + CNT_W'(1);
				2'b01:   level_q <= level_q - CNT_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/gbfp_back.sv
`default_nettype none

module gbfp_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [31:0]    crc_poly,
	input  wire logic           pop_valid,
	input  wire gbfp_pkg::op_t  pop_item,
	output logic                pop_ready,
	output logic                ev_valid,
	output gbfp_pkg::ev_t       ev,
	input  wire logic           ev_ready
);

	localparam int SH_W = $clog2(gbfp_pkg::SHADOW_DEPTH);

	logic [31:0] crc_q, crc_d;
	logic [23:0] crc_lo_q, crc_lo_d;
	logic [7:0]  shadow_q [gbfp_pkg::SHADOW_DEPTH];
	logic [7:0]  shadow_nxt [gbfp_pkg::SHADOW_DEPTH];
	logic        ev_valid_q;
	gbfp_pkg::ev_t ev_q;

	logic        adv;
	logic        do_pop;
	logic        sh_we;
	logic [31:0] crc_in;
	logic [31:0] crc_upd;
	logic [31:0] rcv_word;
	logic        emit;
	gbfp_pkg::ev_t res;

	// take the next item when the output register is free or draining
	assign adv       = !ev_valid_q || ev_ready;
	assign pop_ready = adv;
	assign do_pop    = pop_valid && adv;
	assign ev_valid  = ev_valid_q;
	assign ev        = ev_q;

	// running crc
	assign crc_in  = (pop_item.op == gbfp_pkg::OP_START) ? 32'd0 : crc_q;
	assign crc_upd = gbfp_pkg::crc_byte(crc_in, pop_item.data, crc_poly);
	assign rcv_word = {pop_item.data, crc_lo_q};

	// header shadow with this item's write folded in
	assign sh_we = do_pop
		&& (pop_item.op inside {gbfp_pkg::OP_START, gbfp_pkg::OP_HDR, gbfp_pkg::OP_HDR_LONG})
		&& (pop_item.idx < 12'(gbfp_pkg::SHADOW_DEPTH));

	always_comb begin
		for (int i = 0; i < gbfp_pkg::SHADOW_DEPTH; i++) begin
			shadow_nxt[i] = (sh_we && pop_item.idx[SH_W-1:0] == SH_W'(i)) ? pop_item.data
				: shadow_q[i];
		end
	end

	// crc state and event build
	always_comb begin
		crc_d    = crc_q;
		crc_lo_d = crc_lo_q;
		emit     = 1'b0;
		res.event_kind        = gbfp_pkg::EV_LEN_ERR;
		res.data_byte         = 8'd0;
		res.body_index        = 12'd0;
		res.message_id        = {shadow_nxt[5], shadow_nxt[4]};
		res.body_length       = {shadow_nxt[9], shadow_nxt[8]};
		res.time_status       = shadow_nxt[13];
		res.gps_week          = {shadow_nxt[15], shadow_nxt[14]};
		res.week_milliseconds = {shadow_nxt[19], shadow_nxt[18], shadow_nxt[17],
			shadow_nxt[16]};
		res.received_crc      = 32'd0;
		res.computed_crc      = 32'd0;
		case (pop_item.op)
			gbfp_pkg::OP_START, gbfp_pkg::OP_HDR: begin
				crc_d = crc_upd;
			end
			gbfp_pkg::OP_HDR_LONG: begin
				crc_d = crc_upd;
				emit  = 1'b1;
			end
			gbfp_pkg::OP_SHORT: begin
				emit                  = 1'b1;
				res.message_id        = 16'd0;
				res.body_length       = 16'd0;
				res.time_status       = 8'd0;
				res.gps_week          = 16'd0;
				res.week_milliseconds = 32'd0;
			end
			gbfp_pkg::OP_BODY: begin
				crc_d          = crc_upd;
				emit           = 1'b1;
				res.event_kind = gbfp_pkg::EV_BODY;
				res.data_byte  = pop_item.data;
				res.body_index = pop_item.idx;
			end
			gbfp_pkg::OP_CRC: begin
				case (pop_item.idx[1:0])
					2'd0:    crc_lo_d[7:0]   = pop_item.data;
					2'd1:    crc_lo_d[15:8]  = pop_item.data;
					default: crc_lo_d[23:16] = pop_item.data;
				endcase
			end
			gbfp_pkg::OP_CRC_LAST: begin
				emit             = 1'b1;
				res.event_kind   = (rcv_word == crc_q) ? gbfp_pkg::EV_GOOD : gbfp_pkg::EV_BAD;
				res.received_crc = rcv_word;
				res.computed_crc = crc_q;
			end
			default: ;
		endcase
	end

	// header bytes and event payload
	always_ff @(posedge clk) begin
		if (sh_we) shadow_q[pop_item.idx[SH_W-1:0]] <= pop_item.data;
		if (do_pop && emit) ev_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= '0;
			crc_lo_q   <= '0;
			ev_valid_q <= 1'b0;
		end else begin
			if (do_pop) begin
				crc_q    <= crc_d;
				crc_lo_q <= crc_lo_d;
			end
			if (adv) ev_valid_q <= do_pop && emit;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/gbfp_top_unused_guard.sv
`default_nettype none

// output skid register: holds one event so the back part can keep draining
module gbfp_skid (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire gbfp_pkg::ev_t  in_ev,
	output logic                in_ready,
	output logic                out_valid,
	output gbfp_pkg::ev_t       out_ev,
	input  wire logic           out_ready
);

	logic          full_q;
	gbfp_pkg::ev_t hold_q;

	assign in_ready  = !full_q;
	assign out_valid = in_valid || full_q;
	assign out_ev    = full_q ? hold_q : in_ev;

	// capture an event the sink did not take
	always_ff @(posedge clk) begin
		if (in_valid && !full_q && !out_ready) hold_q <= in_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (full_q) begin
			if (out_ready) full_q <= 1'b0;
		end else if (in_valid && !out_ready) begin
			full_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/gnss_binary_frame_parser.sv
// Binary GNSS frame parser: takes one received byte per item on rx, hunts for three
// configurable sync bytes, reads the header (length byte >= 20, fields at fixed offsets),
// streams each body byte out as an event and ends the frame with a good or crc-mismatch
// event carrying the little-endian crc word and the reflected crc-32 (init zero, no final
// xor) over sync, header and body; short headers and frames over 4096 bytes give a length
// error and the parser returns to hunting. Throughput is one byte per clock while evt is
// taken: the framing front pushes into a queue of QUEUE_DEPTH items, and the back part
// pops one item a cycle, with its combinational crc byte update setting the clock path.
// An event reaches evt through the queue entry and then the back register (the skid stage
// passes through when evt is ready). Registers: 0 sync_first, 1 sync_second,
// 2 sync_third, 3 crc_poly_reflected; write them only while no frame is in flight.
`default_nettype none
`include "assert_macros.svh"

module gnss_binary_frame_parser #(
	parameter int QUEUE_DEPTH = gbfp_pkg::QUEUE_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	gbfp_in_if.sink                                  rx,
	gbfp_out_if.source                               evt,
	input  wire logic                                cfg_we,
	input  wire logic [gbfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [gbfp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	gbfp_pkg::cfg_t cfg_q;
	logic           push_valid;
	logic           push_ready;
	gbfp_pkg::op_t  push_item;
	logic           pop_valid;
	logic           pop_ready;
	gbfp_pkg::op_t  pop_item;
	logic           bk_valid;
	logic           bk_ready;
	gbfp_pkg::ev_t  bk_ev;
	gbfp_pkg::ev_t  out_ev;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= gbfp_pkg::SYNC_FIRST_RST;
			cfg_q.sync_second <= gbfp_pkg::SYNC_SECOND_RST;
			cfg_q.sync_third  <= gbfp_pkg::SYNC_THIRD_RST;
			cfg_q.crc_poly    <= gbfp_pkg::CRC_POLY_RST;
		end else if (cfg_we) begin
			case (gbfp_pkg::cfg_reg_e'(cfg_index))
				gbfp_pkg::CFG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_data[7:0];
				gbfp_pkg::CFG_SYNC_SECOND: cfg_q.sync_second <= cfg_data[7:0];
				gbfp_pkg::CFG_SYNC_THIRD:  cfg_q.sync_third  <= cfg_data[7:0];
				gbfp_pkg::CFG_CRC_POLY:    cfg_q.crc_poly    <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// framing front
	assign rx.ready = push_ready;

	gbfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (rx.valid),
		.in_byte    (rx.rx_byte),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_item  (push_item)
	);

	// queue between front and back
	gbfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	// crc and event back
	gbfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.crc_poly  (cfg_q.crc_poly),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop_ready (pop_ready),
		.ev_valid  (bk_valid),
		.ev        (bk_ev),
		.ev_ready  (bk_ready)
	);

	// output skid stage
	gbfp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (bk_valid),
		.in_ev     (bk_ev),
		.in_ready  (bk_ready),
		.out_valid (evt.valid),
		.out_ev    (out_ev),
		.out_ready (evt.ready)
	);

	assign evt.event_kind        = out_ev.event_kind;
	assign evt.data_byte         = out_ev.data_byte;
	assign evt.body_index        = out_ev.body_index;
	assign evt.message_id        = out_ev.message_id;
	assign evt.body_length       = out_ev.body_length;
	assign evt.time_status       = out_ev.time_status;
	assign evt.gps_week          = out_ev.gps_week;
	assign evt.week_milliseconds = out_ev.week_milliseconds;
	assign evt.received_crc      = out_ev.received_crc;
	assign evt.computed_crc      = out_ev.computed_crc;

	// end-of-frame verdict agrees with the two crc words
	`ASSERT_IMPLIES(a_good_crc_equal, clk, arst_n, evt.valid && evt.event_kind == gbfp_pkg::EV_GOOD, evt.received_crc == evt.computed_crc, "good frame with differing crc words")
	`ASSERT_IMPLIES(a_bad_crc_differs, clk, arst_n, evt.valid && evt.event_kind == gbfp_pkg::EV_BAD, evt.received_crc != evt.computed_crc, "crc mismatch with equal crc words")
	// body items carry no crc words
	`ASSERT_IMPLIES(a_body_no_crc, clk, arst_n, evt.valid && evt.event_kind == gbfp_pkg::EV_BODY, evt.received_crc == 32'd0 && evt.computed_crc == 32'd0, "body item with crc fields set")
	// byte fields only on body items
	`ASSERT_IMPLIES(a_nonbody_no_data, clk, arst_n, evt.valid && evt.event_kind != gbfp_pkg::EV_BODY, evt.data_byte == 8'd0 && evt.body_index == 12'd0, "frame item with byte fields set")

endmodule

`default_nettype wire

FILE: verif/frame_event_checker.sv
module frame_event_checker
	import gbfp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	gbfp_in_if                          rx_mon,
	gbfp_out_if                         evt_mon,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output int                          errors,
	output int                          pending,
	output logic                        hunting
);

	// register shadow
	logic [7:0]  sync1_v;
	logic [7:0]  sync2_v;
	logic [7:0]  sync3_v;
	logic [31:0] poly_v;

	// parser state as the block should hold it
	phase_e      phase;
	logic [15:0] count;
	logic [7:0]  hdr_len;
	logic [7:0]  shadow [SHADOW_DEPTH];
	logic [15:0] body_len;
	logic [31:0] crc_run;
	logic [31:0] crc_rx;

	// events still owed by the block, oldest first
	ev_t expected_events[$];

	// reflected crc-32, one byte, full-width shift form
	function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b,
		input logic [31:0] poly);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		repeat (8) c = (c >> 1) ^ (c[0] ? poly : 32'd0);
		return c;
	endfunction

	function automatic ev_t make_event(input ev_kind_e kind, input logic [7:0] data,
		input logic [11:0] idx, input bit with_hdr, input logic [31:0] rx_crc,
		input logic [31:0] calc_crc);
		ev_t e;
		e = '0;
		e.event_kind = kind;
		e.data_byte = data;
		e.body_index = idx;
		if (with_hdr) begin
			e.message_id = {shadow[5], shadow[4]};
			e.body_length = {shadow[BODY_LEN_HI_AT], shadow[BODY_LEN_LO_AT]};
			e.time_status = shadow[13];
			e.gps_week = {shadow[15], shadow[14]};
			e.week_milliseconds = {shadow[19], shadow[18], shadow[17], shadow[16]};
		end
		e.received_crc = rx_crc;
		e.computed_crc = calc_crc;
		return e;
	endfunction

	task automatic restart();
		phase = PH_HUNT;
		count = '0;
		hdr_len = '0;
		body_len = '0;
		crc_run = '0;
		crc_rx = '0;
	endtask

	// sync and header bytes: keep the first 20, all feed the crc
	task automatic store_byte(input logic [7:0] b);
		if (count < SHADOW_DEPTH) begin
			shadow[count] = b;
		end
		crc_run = crc_update(crc_run, b, poly_v);
		count++;
	endtask

	task automatic parse_byte(input logic [7:0] b);
		logic [15:0] blen_hdr;
		case (phase)
			PH_HUNT: begin
				if (b == sync1_v) begin
					restart();
					store_byte(b);
					phase = PH_SYNC1;
				end
			end
			PH_SYNC1: begin
				if (b == sync2_v) begin
					store_byte(b);
					phase = PH_SYNC2;
				end else begin
					restart();
				end
			end
			PH_SYNC2: begin
				if (b == sync3_v) begin
					store_byte(b);
					phase = PH_LEN;
				end else begin
					restart();
				end
			end
			PH_LEN: begin
				// short header reports at once with bare fields
				if (b < SHADOW_DEPTH) begin
					restart();
					expected_events.push_back(make_event(EV_LEN_ERR, '0, '0, 1'b0, '0, '0));
				end else begin
					hdr_len = b;
					store_byte(b);
					phase = PH_HEADER;
				end
			end
			PH_HEADER: begin
				store_byte(b);
				// header decoded on its last byte
				if (count >= hdr_len) begin
					blen_hdr = {shadow[BODY_LEN_HI_AT], shadow[BODY_LEN_LO_AT]};
					if (int'(hdr_len) + int'(blen_hdr) > MAX_FRAME_BYTES) begin
						expected_events.push_back(make_event(EV_LEN_ERR, '0, '0, 1'b1, '0, '0));
						restart();
					end else begin
						body_len = blen_hdr;
						count = '0;
						crc_rx = '0;
						phase = (blen_hdr == '0) ? PH_CRC : PH_BODY;
					end
				end
			end
			PH_BODY: begin
				expected_events.push_back(make_event(EV_BODY, b, count[11:0], 1'b1, '0, '0));
				crc_run = crc_update(crc_run, b, poly_v);
				count++;
				if (count >= body_len) begin
					count = '0;
					crc_rx = '0;
					phase = PH_CRC;
				end
			end
			PH_CRC: begin
				// crc word arrives little-endian
				crc_rx = crc_rx | ({24'd0, b} << (8 * count[1:0]));
				count++;
				if (count >= CRC_BYTES) begin
					expected_events.push_back(make_event((crc_rx == crc_run) ? EV_GOOD : EV_BAD,
						'0, '0, 1'b1, crc_rx, crc_run));
					restart();
				end
			end
			default: restart();
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	// follow every accepted item on both sides
	always @(posedge clk or negedge arst_n) begin : track
		ev_t want;
		if (!arst_n) begin
			sync1_v = SYNC_FIRST_RST;
			sync2_v = SYNC_SECOND_RST;
			sync3_v = SYNC_THIRD_RST;
			poly_v = CRC_POLY_RST;
			foreach (shadow[i]) shadow[i] = '0;
			restart();
			expected_events.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_e'(cfg_index))
					CFG_SYNC_FIRST:  sync1_v = cfg_data[7:0];
					CFG_SYNC_SECOND: sync2_v = cfg_data[7:0];
					CFG_SYNC_THIRD:  sync3_v = cfg_data[7:0];
					CFG_CRC_POLY:    poly_v = cfg_data;
					default: ;
				endcase
			end
			if (rx_mon.valid && rx_mon.ready) begin
				parse_byte(rx_mon.rx_byte);
			end
			if (evt_mon.valid && evt_mon.ready) begin
				if (expected_events.size() == 0) begin
					$error("event kind %0d with none expected", evt_mon.event_kind);
					errors++;
				end else begin
					want = expected_events.pop_front();
					check_field("event_kind", want.event_kind, evt_mon.event_kind);
					check_field("data_byte", want.data_byte, evt_mon.data_byte);
					check_field("body_index", want.body_index, evt_mon.body_index);
					check_field("message_id", want.message_id, evt_mon.message_id);
					check_field("body_length", want.body_length, evt_mon.body_length);
					check_field("time_status", want.time_status, evt_mon.time_status);
					check_field("gps_week", want.gps_week, evt_mon.gps_week);
					check_field("week_milliseconds", want.week_milliseconds,
						evt_mon.week_milliseconds);
					check_field("received_crc", want.received_crc, evt_mon.received_crc);
					check_field("computed_crc", want.computed_crc, evt_mon.computed_crc);
				end
			end
		end
		pending = expected_events.size();
		hunting = (phase == PH_HUNT);
	end

endmodule

FILE: verif/tb_top.sv
module tb_top;
	import gbfp_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 150;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int   fail_count;
	int   results_due;
	logic parser_idle;
	logic quiet;
	int   stall_cycles;
	int   phase_bytes;

	// register values as last written, used to build frames
	logic [7:0]  sync1_c;
	logic [7:0]  sync2_c;
	logic [7:0]  sync3_c;
	logic [31:0] poly_c;

	gbfp_in_if  rx();
	gbfp_out_if evt();

	gnss_binary_frame_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.evt       (evt),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	frame_event_checker i_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_mon    (rx),
		.evt_mon   (evt),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (fail_count),
		.pending   (results_due),
		.hunting   (parser_idle)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// event side back-pressure
	always @(negedge clk) begin
		evt.ready = quiet || ($urandom_range(99) >= 10);
	end

	// give up when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((rx.valid && rx.ready) || (evt.valid && evt.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("** gnss_binary_frame_parser: FAILED **");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ poly_c;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// one item on rx, with random gaps ahead of it
	task automatic send_byte(input logic [7:0] b);
		while (!quiet && $urandom_range(99) < 10) @(negedge clk);
		rx.rx_byte = b;
		rx.valid = 1'b1;
		do @(posedge clk); while (!rx.ready);
		@(negedge clk);
		rx.valid = 1'b0;
		phase_bytes++;
	endtask

	// fill: 0 random, 1 all zeros, 2 all ones
	task automatic send_frame(input logic [7:0] hlen, input logic [15:0] blen,
		input bit corrupt, input int fill);
		logic [7:0]  frame_q[$];
		logic [7:0]  b;
		logic [31:0] crc;
		frame_q.push_back(sync1_c);
		frame_q.push_back(sync2_c);
		frame_q.push_back(sync3_c);
		frame_q.push_back(hlen);
		// a short header ends the frame at its length byte
		if (hlen >= SHADOW_DEPTH) begin
			for (int i = 4; i < hlen; i++) begin
				case (fill)
					0:       b = $urandom;
					1:       b = 8'h00;
					default: b = 8'hFF;
				endcase
				if (i == BODY_LEN_LO_AT) b = blen[7:0];
				if (i == BODY_LEN_HI_AT) b = blen[15:8];
				frame_q.push_back(b);
			end
			// an oversized frame stops after its header
			if (int'(hlen) + int'(blen) <= MAX_FRAME_BYTES) begin
				for (int i = 0; i < blen; i++) begin
					case (fill)
						0:       b = $urandom;
						1:       b = 8'h00;
						default: b = 8'hFF;
					endcase
					frame_q.push_back(b);
				end
				crc = '0;
				foreach (frame_q[i]) crc = crc_step(crc, frame_q[i]);
				if (corrupt) crc = crc ^ (32'd1 << $urandom_range(31));
				for (int i = 0; i < CRC_BYTES; i++) frame_q.push_back(crc[8*i +: 8]);
			end
		end
		foreach (frame_q[i]) send_byte(frame_q[i]);
	endtask

	task automatic return_to_hunt();
		while (!parser_idle) send_byte(sync1_c ^ 8'h01);
	endtask

	task automatic drain_results();
		while (results_due != 0) @(negedge clk);
	endtask

	// parser hunting, all events out, back part given time to settle
	task automatic quiesce();
		return_to_hunt();
		drain_results();
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_e idx, input logic [31:0] value);
		cfg_index = idx;
		cfg_data = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_SYNC_FIRST:  sync1_c = value[7:0];
			CFG_SYNC_SECOND: sync2_c = value[7:0];
			CFG_SYNC_THIRD:  sync3_c = value[7:0];
			CFG_CRC_POLY:    poly_c = value;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] s3,
		input logic [31:0] poly);
		write_reg(CFG_SYNC_FIRST, {24'd0, s1});
		write_reg(CFG_SYNC_SECOND, {24'd0, s2});
		write_reg(CFG_SYNC_THIRD, {24'd0, s3});
		write_reg(CFG_CRC_POLY, poly);
	endtask

	// mostly good frames with random content, mixed with errors and noise
	task automatic random_traffic(input int n_items, input bit calm);
		int          pick;
		logic [7:0]  hlen;
		logic [15:0] blen;
		logic [7:0]  b;
		phase_bytes = 0;
		while (phase_bytes < n_items) begin
			quiet = calm && (phase_bytes < n_items / 2);
			pick = $urandom_range(99);
			hlen = ($urandom_range(9) == 0) ? $urandom_range(255, 20) : $urandom_range(32, 20);
			blen = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(16);
			if (pick < 70) begin
				send_frame(hlen, blen, 1'b0, 0);
			end else if (pick < 78) begin
				send_frame(hlen, blen, 1'b1, 0);
			end else if (pick < 83) begin
				send_frame($urandom_range(19), blen, 1'b0, 0);
			end else if (pick < 88) begin
				send_frame(hlen, $urandom_range(65535, MAX_FRAME_BYTES + 1 - hlen), 1'b0, 0);
			end else if (pick < 94) begin
				// broken sync on the second or third byte
				send_byte(sync1_c);
				if ($urandom_range(1)) begin
					send_byte(sync2_c);
					do b = $urandom; while (b == sync3_c);
				end else begin
					do b = $urandom; while (b == sync2_c);
				end
				send_byte(b);
			end else begin
				repeat ($urandom_range(8, 1)) send_byte($urandom);
				return_to_hunt();
			end
			if ($urandom_range(99) < 3) drain_results();
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		evt.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SYNC_FIRST;
		cfg_data = '0;
		quiet = 1'b0;
		stall_cycles = 0;
		phase_bytes = 0;
		sync1_c = SYNC_FIRST_RST;
		sync2_c = SYNC_SECOND_RST;
		sync3_c = SYNC_THIRD_RST;
		poly_c = CRC_POLY_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed cases on reset values
		send_frame(28, 0, 1'b0, 0);
		send_frame(20, 1, 1'b0, 1);
		send_frame(20, 5, 1'b0, 2);
		send_frame(255, 2, 1'b0, 0);
		send_frame(20, 3, 1'b1, 0);
		send_frame(19, 0, 1'b0, 0);
		send_frame(0, 0, 1'b0, 0);
		send_frame(20, MAX_FRAME_BYTES - 19, 1'b0, 0);
		send_frame(255, 16'hFFFF, 1'b0, 2);
		// repeated first sync byte is not looked at again
		send_byte(sync1_c);
		send_byte(sync1_c);
		send_byte(sync2_c);
		send_byte(sync3_c);
		send_frame(21, 2, 1'b0, 0);
		// wrong third sync byte
		send_byte(sync1_c);
		send_byte(sync2_c);
		send_byte(sync3_c ^ 8'h80);
		send_frame(20, 4, 1'b0, 0);
		random_traffic(ITEMS_PER_PHASE, 1'b0);

		quiesce();
		set_config($urandom, $urandom, $urandom, $urandom);
		random_traffic(ITEMS_PER_PHASE, 1'b1);

		quiesce();
		set_config(8'h00, 8'hFF, 8'h00, 32'h0000_0000);
		random_traffic(ITEMS_PER_PHASE, 1'b0);

		quiesce();
		set_config(8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		random_traffic(ITEMS_PER_PHASE, 1'b0);

		drain_results();
		repeat (10) @(negedge clk);
		if (fail_count == 0) begin
			$display("** gnss_binary_frame_parser: PASSED **");
		end else begin
			$display("** gnss_binary_frame_parser: FAILED **");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/gbfp_pkg.sv
hw/rtl/gbfp_in_if.sv
hw/rtl/gbfp_out_if.sv
hw/rtl/gbfp_front.sv
hw/rtl/gbfp_queue.sv
hw/rtl/gbfp_back.sv
hw/rtl/gbfp_top_unused_guard.sv
hw/rtl/gnss_binary_frame_parser.sv
verif/frame_event_checker.sv
verif/tb_top.sv
